### hdl/nv2rgb_pkg.sv
// Shared types and constants for the NV21 to RGBA converter.
package nv2rgb_pkg;

    localparam int CFG_WIDTH           = 13;
    localparam int MAX_DIM_DEFAULT     = 4096;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [CFG_WIDTH-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [CFG_WIDTH-1:0] FRAME_HEIGHT_RESET = 13'd480;

    localparam logic [7:0] CHROMA_OFFSET = 8'd128;
    localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // One classified pixel as it travels from the front end to the color math.
    typedef struct packed {
        logic [7:0]        luma;
        logic signed [7:0] cr;
        logic signed [7:0] cb;
        logic              eol;
        logic              eof;
    } pix_entry_t;

endpackage

### hdl/nv2rgb_front.sv
// Front end: accepts pixels, latches chroma pairs, tracks raster position.
module nv2rgb_front #(
    parameter int MAX_DIM = nv2rgb_pkg::MAX_DIM_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [0:0]                       cfg_index,
    input  logic [nv2rgb_pkg::CFG_WIDTH-1:0] cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       luma,
    input  logic [7:0]                       chroma_v,
    input  logic [7:0]                       chroma_u,
    input  logic                             queue_full,
    output logic                             push,
    output nv2rgb_pkg::pix_entry_t           push_entry
);

    localparam int CW = $clog2(MAX_DIM);

    logic [nv2rgb_pkg::CFG_WIDTH-1:0] width_reg;
    logic [nv2rgb_pkg::CFG_WIDTH-1:0] height_reg;
    logic [7:0]                       held_cr_reg, held_cr_next;
    logic [7:0]                       held_cb_reg, held_cb_next;
    logic [CW-1:0]                    col_reg, col_next;
    logic [CW-1:0]                    row_reg, row_next;
    logic [CW-1:0]                    last_col;
    logic [CW-1:0]                    last_row;
    logic                             line_end;
    logic                             frame_end;

    // Clamp a register to 1..MAX_DIM and return the last index.
    function automatic logic [CW-1:0] last_index(input logic [nv2rgb_pkg::CFG_WIDTH-1:0] dim);
        logic [31:0] dim_x;
        dim_x = 32'(dim);
        if (dim_x == 32'd0) begin
            return '0;
        end
        else if (dim_x > 32'(MAX_DIM)) begin
            return CW'(MAX_DIM - 1);
        end
        return CW'(dim_x - 32'd1);
    endfunction

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;
    assign last_col = last_index(width_reg);
    assign last_row = last_index(height_reg);

    always_comb
    begin
        held_cr_next = held_cr_reg;
        held_cb_next = held_cb_reg;
        if (!col_reg[0])
        begin
            held_cr_next = chroma_v - nv2rgb_pkg::CHROMA_OFFSET;
            held_cb_next = chroma_u - nv2rgb_pkg::CHROMA_OFFSET;
        end

        line_end  = (col_reg >= last_col);
        frame_end = line_end && (row_reg >= last_row);
        col_next  = line_end ? '0 : col_reg + CW'(1);
        row_next  = row_reg;
        if (line_end)
        begin
            row_next = frame_end ? '0 : row_reg + CW'(1);
        end
    end

    assign push_entry.luma = luma;
    assign push_entry.cr   = signed'(held_cr_next);
    assign push_entry.cb   = signed'(held_cb_next);
    assign push_entry.eol  = line_end;
    assign push_entry.eof  = frame_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= nv2rgb_pkg::FRAME_WIDTH_RESET;
            height_reg  <= nv2rgb_pkg::FRAME_HEIGHT_RESET;
            held_cr_reg <= '0;
            held_cb_reg <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    nv2rgb_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    nv2rgb_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (push)
            begin
                held_cr_reg <= held_cr_next;
                held_cb_reg <= held_cb_next;
                col_reg     <= col_next;
                row_reg     <= row_next;
            end
        end
    end

    // A beat that closes a line leaves the column counter at zero.
    a_eol_wraps_column: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_entry.eol |=> col_reg == '0)
        else $error("column counter did not wrap after end of line");

    // End of frame only ever comes with end of line.
    a_eof_has_eol: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_entry.eof |-> push_entry.eol)
        else $error("end of frame without end of line");

endmodule

### hdl/nv2rgb_queue.sv
// Small register queue between the front end and the color math.
module nv2rgb_queue #(
    parameter int DEPTH = nv2rgb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  nv2rgb_pkg::pix_entry_t push_entry,
    output logic                   full,
    input  logic                   pop,
    output logic                   not_empty,
    output nv2rgb_pkg::pix_entry_t pop_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    nv2rgb_pkg::pix_entry_t slot_reg [DEPTH];
    logic [PW-1:0]          wr_ptr_reg;
    logic [PW-1:0]          rd_ptr_reg;
    logic [NW-1:0]          count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign full      = (count_reg == NW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from an empty queue");

endmodule

### hdl/nv2rgb_back.sv
// Back end: shift-add color math, clamping and the output register.
module nv2rgb_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   not_empty,
    input  nv2rgb_pkg::pix_entry_t pop_entry,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             red,
    output logic [7:0]             green,
    output logic [7:0]             blue,
    output logic                   end_of_line,
    output logic                   end_of_frame
);

    logic              out_valid_reg;
    logic [7:0]        red_reg, red_next;
    logic [7:0]        green_reg, green_next;
    logic [7:0]        blue_reg, blue_next;
    logic              eol_reg;
    logic              eof_reg;
    logic [8:0]        y_scaled;
    logic signed [11:0] y_s;
    logic signed [11:0] cr_s;
    logic signed [11:0] cb_s;
    logic signed [11:0] r_sum;
    logic signed [11:0] g_sum;
    logic signed [11:0] b_sum;

    function automatic logic [7:0] clamp_byte(input logic signed [11:0] v);
        if (v < 0) begin
            return 8'd0;
        end
        else if (v > 12'sd255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    always_comb
    begin
        // Luma times 1 + 1/8 + 1/32, truncating each term.
        y_scaled = 9'(pop_entry.luma) + 9'(pop_entry.luma >> 3) + 9'(pop_entry.luma >> 5);
        y_s  = signed'({3'b000, y_scaled});
        cr_s = 12'(pop_entry.cr);
        cb_s = 12'(pop_entry.cb);
        r_sum = y_s + cr_s + (cr_s >>> 1) + (cr_s >>> 4) + (cr_s >>> 5);
        g_sum = y_s - (cb_s >>> 1) + (cb_s >>> 3) - cr_s + (cr_s >>> 3) + (cr_s >>> 4);
        b_sum = y_s + (cb_s <<< 1);
        red_next   = clamp_byte(r_sum);
        green_next = clamp_byte(g_sum);
        blue_next  = clamp_byte(b_sum);
    end

    assign pop          = not_empty && (!out_valid_reg || out_ready);
    assign out_valid    = out_valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign end_of_line  = eol_reg;
    assign end_of_frame = eof_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            eol_reg   <= pop_entry.eol;
            eof_reg   <= pop_entry.eof;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // A beat taken from the queue always shows up at the output next cycle.
    a_pop_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid)
        else $error("popped beat did not reach the output register");

endmodule

### hdl/nv21_to_rgba_converter_unit.sv
// Top level of the NV21 to RGBA pixel converter.
// Path: an accepted pixel is written into the queue, then taken into the output register.
// Throughput: one pixel per clock; the front end, a two-beat queue and the color math
// each advance one beat a cycle, and the input stalls only when that queue is full.
// Reset: asynchronous and active low; it restores width 640 and height 480, clears the
// raster counters and the held chroma pair, and empties the queue and the output register.
module nv21_to_rgba_converter_unit #(
    parameter int MAX_DIM     = nv2rgb_pkg::MAX_DIM_DEFAULT,
    parameter int QUEUE_DEPTH = nv2rgb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [0:0]                       cfg_index,
    input  logic [nv2rgb_pkg::CFG_WIDTH-1:0] cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       luma,
    input  logic [7:0]                       chroma_v,
    input  logic [7:0]                       chroma_u,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       red,
    output logic [7:0]                       green,
    output logic [7:0]                       blue,
    output logic [7:0]                       alpha,
    output logic                             end_of_line,
    output logic                             end_of_frame
);

    // The front end classifies each input beat: even columns latch a fresh
    // chroma pair (offset by 128), odd columns reuse it, and the column and
    // row counters mark line and frame ends against the clamped dimensions.
    logic                   push;
    logic                   queue_full;
    logic                   pop;
    logic                   queue_not_empty;
    nv2rgb_pkg::pix_entry_t push_entry;
    nv2rgb_pkg::pix_entry_t pop_entry;

    nv2rgb_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .luma       (luma),
        .chroma_v   (chroma_v),
        .chroma_u   (chroma_u),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // The queue decouples the two halves so that a stalled consumer does not
    // immediately stall the producer and vice versa.
    nv2rgb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (queue_not_empty),
        .pop_entry  (pop_entry)
    );

    // The back end does the shift-add color math and clamping, then holds
    // the result in an output register until the consumer takes the beat.
    nv2rgb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .not_empty    (queue_not_empty),
        .pop_entry    (pop_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .end_of_line  (end_of_line),
        .end_of_frame (end_of_frame)
    );

    // Every pixel is fully opaque.
    assign alpha = nv2rgb_pkg::ALPHA_OPAQUE;

endmodule

### dv/tb_top.sv
// Self-checking testbench for the NV21 to RGBA pixel converter.
`timescale 1ns / 1ps

module tb_top;

    // Cycles without any accepted beat or register write before the run is declared hung.
    // The worst legitimate gap is a long random receiver stall or the short settle
    // before a register write, both far below this.
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_PIXELS = 210;
    localparam int PHASE_COUNT  = 9;

    // Handshake pacing modes for the random part of the run.
    typedef enum int {
        PACE_SLOW_RECEIVER,
        PACE_SLOW_SENDER,
        PACE_FULL
    } pace_t;

    typedef struct packed {
        logic [7:0] y_byte;
        logic [7:0] v_byte;
        logic [7:0] u_byte;
    } nv21_px_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       eol;
        logic       eof;
    } rgba_px_t;

    // Every block input starts at a known value; the driver and monitor take over after reset.
    logic                             clk          = 1'b0;
    logic                             rst_n        = 1'b0;
    logic                             cfg_write    = 1'b0;
    logic [0:0]                       cfg_index    = nv2rgb_pkg::REG_FRAME_WIDTH;
    logic [nv2rgb_pkg::CFG_WIDTH-1:0] cfg_data     = '0;
    logic                             in_valid     = 1'b0;
    logic                             in_ready;
    logic [7:0]                       luma         = 8'd0;
    logic [7:0]                       chroma_v     = 8'd0;
    logic [7:0]                       chroma_u     = 8'd0;
    logic                             out_valid;
    logic                             out_ready    = 1'b0;
    logic [7:0]                       red;
    logic [7:0]                       green;
    logic [7:0]                       blue;
    logic [7:0]                       alpha;
    logic                             end_of_line;
    logic                             end_of_frame;

    // Pixels waiting to be driven, and the RGBA beats the converter owes us, oldest first.
    nv21_px_t pixel_queue[$];
    rgba_px_t rgba_expected[$];

    // Our own copy of the converter's registers and raster state.
    logic [nv2rgb_pkg::CFG_WIDTH-1:0] model_width  = nv2rgb_pkg::FRAME_WIDTH_RESET;
    logic [nv2rgb_pkg::CFG_WIDTH-1:0] model_height = nv2rgb_pkg::FRAME_HEIGHT_RESET;
    logic signed [7:0]                held_cr      = 8'sd0;
    logic signed [7:0]                held_cb      = 8'sd0;
    int                               column_pos   = 0;
    int                               row_pos      = 0;

    pace_t pace           = PACE_FULL;
    int    mismatch_count = 0;
    int    stall_cycles   = 0;

    // Frame geometry for each random phase. Zero and values past the maximum dimension
    // are there on purpose, and since the raster counters carry over from one phase to
    // the next, shrinking the geometry also lands in the middle of a line or frame.
    int phase_width  [PHASE_COUNT] = '{1, 3, 8191, 2, 5, 0, 4096, 17, 640};
    int phase_height [PHASE_COUNT] = '{1, 2, 4, 0, 8191, 3, 1, 2, 480};

    nv21_to_rgba_converter_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .luma         (luma),
        .chroma_v     (chroma_v),
        .chroma_u     (chroma_u),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .end_of_line  (end_of_line),
        .end_of_frame (end_of_frame)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // A register value of zero means one, and anything past the maximum means the maximum.
    function automatic int clip_dim(input int r);
        if (r == 0)
            return 1;
        if (r > nv2rgb_pkg::MAX_DIM_DEFAULT)
            return nv2rgb_pkg::MAX_DIM_DEFAULT;
        return r;
    endfunction

    function automatic logic [7:0] saturate_byte(input int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    // Converts one accepted pixel and queues the RGBA beat it must produce.
    // Chroma is latched only on even columns; the shifts on the signed terms are
    // arithmetic, so they round toward minus infinity.
    function automatic void convert_pixel(input logic [7:0] y_in, input logic [7:0] v_in,
                                          input logic [7:0] u_in);
        int       y;
        int       cr;
        int       cb;
        int       r;
        int       g;
        int       b;
        int       w;
        int       h;
        rgba_px_t px;

        w = clip_dim(int'(model_width));
        h = clip_dim(int'(model_height));
        if (column_pos[0] == 1'b0) begin
            held_cr = v_in - nv2rgb_pkg::CHROMA_OFFSET;
            held_cb = u_in - nv2rgb_pkg::CHROMA_OFFSET;
        end
        cr = held_cr;
        cb = held_cb;

        y = int'(y_in);
        y = y + (y >> 3) + (y >> 5);
        r = y + cr + (cr >>> 1) + (cr >>> 4) + (cr >>> 5);
        g = y - (cb >>> 1) + (cb >>> 3) - cr + (cr >>> 3) + (cr >>> 4);
        b = y + cb * 2;

        px.eol = 1'b0;
        px.eof = 1'b0;
        // A counter at or past the last index ends its line or frame here, which also
        // covers geometry that shrank while a frame was in progress.
        if (column_pos >= w - 1) begin
            px.eol     = 1'b1;
            column_pos = 0;
            if (row_pos >= h - 1) begin
                px.eof  = 1'b1;
                row_pos = 0;
            end
            else
                row_pos++;
        end
        else
            column_pos++;

        px.red   = saturate_byte(r);
        px.green = saturate_byte(g);
        px.blue  = saturate_byte(b);
        px.alpha = nv2rgb_pkg::ALPHA_OPAQUE;
        rgba_expected.push_back(px);
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t ns: MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Biased byte source: the chroma midpoint, its neighbor and both rails turn up often.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7, 0))
            0: return 8'd0;
            1: return 8'd255;
            2: return nv2rgb_pkg::CHROMA_OFFSET;
            3: return nv2rgb_pkg::CHROMA_OFFSET - 8'd1;
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    function automatic bit sender_holds_off();
        case (pace)
            PACE_SLOW_RECEIVER: return $urandom_range(99, 0) < 34;
            PACE_SLOW_SENDER: return $urandom_range(99, 0) < 77;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_holds_off();
        case (pace)
            PACE_SLOW_RECEIVER: return $urandom_range(99, 0) < 77;
            PACE_SLOW_SENDER: return $urandom_range(99, 0) < 34;
            default: return 1'b0;
        endcase
    endfunction

    task automatic queue_pixel(input logic [7:0] y_in, input logic [7:0] v_in,
                               input logic [7:0] u_in);
        nv21_px_t px;

        px.y_byte = y_in;
        px.v_byte = v_in;
        px.u_byte = u_in;
        pixel_queue.push_back(px);
    endtask

    // Sampled on the falling edge so that the driver and monitor have finished the
    // rising edge before we look at their queues.
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (pixel_queue.size() != 0 || in_valid || rgba_expected.size() != 0);
    endtask

    // One register write: enable high for exactly one rising edge.
    task automatic write_frame_reg(input nv2rgb_pkg::cfg_reg_t idx, input int value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[nv2rgb_pkg::CFG_WIDTH-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == nv2rgb_pkg::REG_FRAME_WIDTH)
            model_width = value[nv2rgb_pkg::CFG_WIDTH-1:0];
        else
            model_height = value[nv2rgb_pkg::CFG_WIDTH-1:0];
    endtask

    // Registers only change once the converter has handed back every beat it owes.
    // Every pixel produces a result, so nothing is left in flight after that; the extra
    // edges waited before the writes are just margin.
    task automatic reframe(input int w, input int h);
        wait_for_drain();
        repeat (2) @(posedge clk);
        write_frame_reg(nv2rgb_pkg::REG_FRAME_WIDTH, w);
        write_frame_reg(nv2rgb_pkg::REG_FRAME_HEIGHT, h);
    endtask

    // Driver: offers the next queued pixel whenever the input side is free, and runs
    // the prediction for every beat the converter takes.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        nv21_px_t px;

        if (!rst_n) begin
            in_valid <= 1'b0;
            luma     <= 8'd0;
            chroma_v <= 8'd0;
            chroma_u <= 8'd0;
        end
        else begin
            if (in_valid && in_ready)
                convert_pixel(luma, chroma_v, chroma_u);
            // Valid only drops or moves on once the current beat has been taken.
            if (!in_valid || in_ready) begin
                if (pixel_queue.size() != 0 && !sender_holds_off()) begin
                    px        = pixel_queue.pop_front();
                    in_valid <= 1'b1;
                    luma     <= px.y_byte;
                    chroma_v <= px.v_byte;
                    chroma_u <= px.u_byte;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: every RGBA beat is checked field by field against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        rgba_px_t want;

        if (!rst_n)
            out_ready <= 1'b0;
        else begin
            if (out_valid && out_ready) begin
                if (rgba_expected.size() == 0)
                    flag_mismatch("output beat with no pixel pending, red", red, -1);
                else begin
                    want = rgba_expected.pop_front();
                    if (red !== want.red)
                        flag_mismatch("red", red, want.red);
                    if (green !== want.green)
                        flag_mismatch("green", green, want.green);
                    if (blue !== want.blue)
                        flag_mismatch("blue", blue, want.blue);
                    if (alpha !== want.alpha)
                        flag_mismatch("alpha", alpha, want.alpha);
                    if (end_of_line !== want.eol)
                        flag_mismatch("end_of_line", end_of_line, want.eol);
                    if (end_of_frame !== want.eof)
                        flag_mismatch("end_of_frame", end_of_frame, want.eof);
                end
            end
            out_ready <= !receiver_holds_off();
        end
    end

    // Watchdog: a run of cycles with no handshake and no register write means the
    // converter has hung.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
                stall_cycles <= 0;
            else if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("%0t ns: no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus sequence: reset, a directed part, then random phases under each pacing mode.
    initial
    begin
        int remaining;
        int chunk;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, first under the reset geometry. The rails of luma meet both
        // chroma extremes and the midpoint, so every color channel clamps at both ends;
        // odd columns carry different chroma that must be ignored.
        pace = PACE_FULL;
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'd255, 8'd0, 8'd255);
        queue_pixel(8'd128, 8'd255, 8'd0);
        queue_pixel(8'd0, 8'd128, 8'd128);
        queue_pixel(8'd255, 8'd127, 8'd129);

        // Zero width and height count as one: every pixel ends a line and a frame, and
        // the column left at eight by the pixels above wraps on the first of them.
        reframe(0, 0);
        queue_pixel(8'd17, 8'd200, 8'd40);
        queue_pixel(8'd240, 8'd60, 8'd220);
        queue_pixel(8'd99, 8'd128, 8'd1);

        // Largest register value, which the converter limits to the maximum dimension.
        reframe(8191, 8191);
        queue_pixel(8'd1, 8'd254, 8'd2);
        queue_pixel(8'd254, 8'd1, 8'd253);
        queue_pixel(8'd64, 8'd192, 8'd64);

        // Shrinking the width mid-line ends the line on the next pixel; two more lines
        // of two then close the frame.
        reframe(2, 3);
        queue_pixel(8'd200, 8'd30, 8'd90);
        queue_pixel(8'd10, 8'd230, 8'd170);
        queue_pixel(8'd128, 8'd129, 8'd127);
        queue_pixel(8'd55, 8'd0, 8'd255);
        queue_pixel(8'd180, 8'd255, 8'd0);
        queue_pixel(8'd33, 8'd77, 8'd222);
        queue_pixel(8'd222, 8'd33, 8'd77);

        // Shrinking the height while on the second row ends the frame at the next line end.
        reframe(2, 1);
        queue_pixel(8'd90, 8'd90, 8'd90);
        queue_pixel(8'd160, 8'd160, 8'd160);

        // Random phases. Each phase runs in chunks, and the sender stops after each chunk
        // until every outstanding beat has come back.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            reframe(phase_width[p], phase_height[p]);
            pace      = pace_t'(p / 3);
            remaining = PHASE_PIXELS;
            while (remaining > 0) begin
                chunk = $urandom_range(80, 20);
                if (chunk > remaining)
                    chunk = remaining;
                repeat (chunk) queue_pixel(pick_byte(), pick_byte(), pick_byte());
                remaining -= chunk;
                wait_for_drain();
            end
        end

        // Everything has been accepted and answered; give the converter time to show
        // any stray beat before the verdict.
        wait_for_drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
